// ===== hdl/tsr_pkg.sv =====
// Shared types, field widths and command codes for the text screen renderer.
`timescale 1ns / 1ps

package tsr_pkg;

   // Default screen and glyph store geometry
   localparam int SCREEN_COLUMNS_DEF = 40;
   localparam int SCREEN_ROWS_DEF    = 25;
   localparam int GLYPH_BYTES_DEF    = 2048;

   // Field widths, fixed by the channel format
   localparam int FUNC_W  = 3;
   localparam int COL_W   = 6;
   localparam int ROW_W   = 5;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int GADDR_W = 11;
   localparam int GBYTE_W = 8;
   localparam int LINE_W  = 3;
   localparam int PIX_W   = 32;
   localparam int GLYPH_LINES = 8;

   localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
   localparam logic [LINE_W-1:0] LAST_LINE  = 3'd7;

   // Command codes
   typedef logic [FUNC_W-1:0] func_type;
   localparam func_type FUNC_LOAD_GLYPH   = 3'd0;
   localparam func_type FUNC_WRITE_CELL   = 3'd1;
   localparam func_type FUNC_SCROLL_UP    = 3'd2;
   localparam func_type FUNC_SCROLL_LEFT  = 3'd3;
   localparam func_type FUNC_SCROLL_DOWN  = 3'd4;
   localparam func_type FUNC_SCROLL_RIGHT = 3'd5;
   localparam func_type FUNC_RENDER       = 3'd6;

   // One glyph line ready for pixel expansion
   typedef struct packed {
      logic [GBYTE_W-1:0] glyph;
      logic [COLOR_W-1:0] fore;
      logic [COLOR_W-1:0] back;
      logic [LINE_W-1:0]  line;
   } line_job_type;

endpackage

// ===== hdl/tsr_channels.sv =====
// Valid/ready channel interfaces for commands and rendered lines.
`timescale 1ns / 1ps

interface tsr_req_if import tsr_pkg::*; ();
   logic                valid;
   logic                ready;
   func_type            func;
   logic [COL_W-1:0]    column;
   logic [ROW_W-1:0]    row_index;
   logic [CHAR_W-1:0]   char_code;
   logic [COLOR_W-1:0]  fore_color;
   logic [GADDR_W-1:0]  glyph_address;
   logic [GBYTE_W-1:0]  glyph_byte;

   modport source (output valid, func, column, row_index, char_code, fore_color,
                   glyph_address, glyph_byte, input ready);
   modport sink   (input valid, func, column, row_index, char_code, fore_color,
                   glyph_address, glyph_byte, output ready);
endinterface

interface tsr_rsp_if import tsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   line_pixels;
   logic [LINE_W-1:0]  line_number;
   logic               last_line;

   modport source (output valid, line_pixels, line_number, last_line, input ready);
   modport sink   (input valid, line_pixels, line_number, last_line, output ready);
endinterface

// ===== hdl/tsr_pixel_out.sv =====
// Glyph line to palette-index expansion and the result output register.
`timescale 1ns / 1ps

module tsr_pixel_out import tsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  line_job_type  job,
   tsr_rsp_if.source     rsp_chan
);

   logic              valid_ff, valid_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [LINE_W-1:0] line_ff;
   logic              last_ff;

   // Expand glyph bits, MSB is the leftmost pixel in the top nibble
   always_comb begin
      pix_in = '0;
      for (int i = 0; i < GLYPH_LINES; i++) begin
         pix_in[PIX_W-1-COLOR_W*i -: COLOR_W] = job.glyph[GBYTE_W-1-i] ? job.fore : job.back;
      end
   end

   // Output beat held until taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff  <= pix_in;
         line_ff <= job.line;
         last_ff <= (job.line == LAST_LINE);
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.line_pixels = pix_ff;
   assign rsp_chan.line_number = line_ff;
   assign rsp_chan.last_line   = last_ff;

endmodule

// ===== hdl/text_screen_scroll_and_glyph_render.sv =====
// Text screen store with one-cell scrolling and glyph line rendering.
// Reset: synchronous; a clearing pass then writes space/color 0 to all
//   SCREEN_COLUMNS*SCREEN_ROWS cells with req not ready.
// Glyph load, cell write, unused code: done without leaving idle. Scroll: one cell per cycle through
//   the cell memory read/write port, with req not ready until every cell is written back.
// Render: cell read, then per line a glyph read and the output register, eight beats;
//   a line is issued only once the last glyph read is done and the output register is free.
`timescale 1ns / 1ps

module text_screen_scroll_and_glyph_render import tsr_pkg::*; #(
   parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
   parameter int GLYPH_BYTES    = GLYPH_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   tsr_req_if.sink             req_chan,
   tsr_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic [COLOR_W-1:0]  csr_wr_data
);

   localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int CIDX_W     = $clog2(CELL_COUNT);
   localparam int CCOL_W     = $clog2(SCREEN_COLUMNS);
   localparam int RROW_W     = $clog2(SCREEN_ROWS);
   localparam int GIDX_W     = $clog2(GLYPH_BYTES);
   localparam int CELL_W     = CHAR_W + COLOR_W;

   localparam logic [CIDX_W-1:0] LAST_CELL = CIDX_W'(CELL_COUNT - 1);
   localparam logic [CIDX_W-1:0] ROW_STEP  = CIDX_W'(SCREEN_COLUMNS);
   localparam logic [CCOL_W-1:0] COL_LAST  = CCOL_W'(SCREEN_COLUMNS - 1);
   localparam logic [RROW_W-1:0] ROW_LAST  = RROW_W'(SCREEN_ROWS - 1);

   // Sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_RCELL  = 3'd3;
   localparam logic [2:0] ST_RLINE  = 3'd4;

   // Memories: cell = {char, color}
   logic [CELL_W-1:0]  cell_mem  [CELL_COUNT];
   logic [GBYTE_W-1:0] glyph_mem [GLYPH_BYTES];

   logic [2:0]          state_ff, state_in;
   logic [CIDX_W-1:0]   idx_ff, idx_in;
   logic [CCOL_W-1:0]   col_ff, col_in;
   logic [RROW_W-1:0]   row_ff, row_in;
   func_type            op_ff, op_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic                sc_wr_ff, sc_wr_in;
   logic [CIDX_W-1:0]   sc_waddr_ff, sc_waddr_in;
   logic                sc_space_ff, sc_space_in;
   logic                gl_pend_ff, gl_pend_in;
   logic [LINE_W-1:0]   gl_line_ff, gl_line_in;
   logic [COLOR_W-1:0]  bg_ff, bg_in;
   logic [CELL_W-1:0]   rd_cell_ff;
   logic [GBYTE_W-1:0]  gl_rd_ff;

   logic                req_acc;
   logic                on_screen;
   logic [CIDX_W-1:0]   req_cell;
   logic                inc;
   logic                vacated;
   logic [CIDX_W-1:0]   delta;
   logic [CIDX_W-1:0]   sc_src;
   logic                line_issue;
   logic                cw_en;
   logic [CIDX_W-1:0]   cw_addr;
   logic [CELL_W-1:0]   cw_data;
   logic                cr_en;
   logic [CIDX_W-1:0]   cr_addr;
   logic [GIDX_W-1:0]   gr_addr;
   line_job_type        job;

   // Command decode
   assign req_chan.ready = (state_ff == ST_IDLE) && !sc_wr_ff;
   assign req_acc   = req_chan.valid && req_chan.ready;
   assign on_screen = (32'(req_chan.column) < SCREEN_COLUMNS) &&
                      (32'(req_chan.row_index) < SCREEN_ROWS);
   assign req_cell  = CIDX_W'(32'(req_chan.row_index) * SCREEN_COLUMNS +
                              32'(req_chan.column));

   // Scroll walk: source cell and vacated edge
   assign inc   = (op_ff == FUNC_SCROLL_UP) || (op_ff == FUNC_SCROLL_LEFT);
   assign delta = ((op_ff == FUNC_SCROLL_LEFT) || (op_ff == FUNC_SCROLL_RIGHT)) ?
                  CIDX_W'(1) : ROW_STEP;

   always_comb begin
      unique case (op_ff)
         FUNC_SCROLL_UP:   vacated = (row_ff == ROW_LAST);
         FUNC_SCROLL_DOWN: vacated = (row_ff == '0);
         FUNC_SCROLL_LEFT: vacated = (col_ff == COL_LAST);
         default:          vacated = (col_ff == '0);
      endcase
   end

   assign sc_src = vacated ? idx_ff : (inc ? idx_ff + delta : idx_ff - delta);

   // Glyph line issue when the output register is free next cycle
   assign line_issue = (state_ff == ST_RLINE) && !gl_pend_ff &&
                       (!rsp_chan.valid || rsp_chan.ready);
   assign gr_addr    = GIDX_W'({rd_cell_ff[CELL_W-1 -: CHAR_W], line_ff});

   // Cell memory port select
   always_comb begin
      cw_en   = 1'b0;
      cw_addr = idx_ff;
      cw_data = {SPACE_CODE, {COLOR_W{1'b0}}};
      priority if (state_ff == ST_CLEAR) begin
         cw_en = 1'b1;
      end else if (sc_wr_ff) begin
         cw_en   = 1'b1;
         cw_addr = sc_waddr_ff;
         cw_data = {sc_space_ff ? SPACE_CODE : rd_cell_ff[CELL_W-1 -: CHAR_W],
                    rd_cell_ff[COLOR_W-1:0]};
      end else if (req_acc && (req_chan.func == FUNC_WRITE_CELL) && on_screen) begin
         cw_en   = 1'b1;
         cw_addr = req_cell;
         cw_data = {req_chan.char_code, req_chan.fore_color};
      end else begin
         cw_en = 1'b0;
      end
   end

   assign cr_en   = (state_ff == ST_SCROLL) ||
                    (req_acc && (req_chan.func == FUNC_RENDER) && on_screen);
   assign cr_addr = (state_ff == ST_SCROLL) ? sc_src : req_cell;

   always_ff @(posedge clock) begin
      if (cw_en) begin
         cell_mem[cw_addr] <= cw_data;
      end
      if (cr_en) begin
         rd_cell_ff <= cell_mem[cr_addr];
      end
   end

   // Glyph memory
   always_ff @(posedge clock) begin
      if (req_acc && (req_chan.func == FUNC_LOAD_GLYPH)) begin
         glyph_mem[GIDX_W'(req_chan.glyph_address)] <= req_chan.glyph_byte;
      end
      if (line_issue) begin
         gl_rd_ff <= glyph_mem[gr_addr];
      end
   end

   // Background register
   assign bg_in = csr_wr_en ? csr_wr_data : bg_ff;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      op_in       = op_ff;
      line_in     = line_ff;
      sc_wr_in    = 1'b0;
      sc_waddr_in = sc_waddr_ff;
      sc_space_in = sc_space_ff;
      gl_pend_in  = 1'b0;
      gl_line_in  = gl_line_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            idx_in = idx_ff + CIDX_W'(1);
            if (idx_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_chan.func)
                  FUNC_SCROLL_UP, FUNC_SCROLL_LEFT: begin
                     op_in    = req_chan.func;
                     idx_in   = '0;
                     col_in   = '0;
                     row_in   = '0;
                     state_in = ST_SCROLL;
                  end
                  FUNC_SCROLL_DOWN, FUNC_SCROLL_RIGHT: begin
                     op_in    = req_chan.func;
                     idx_in   = LAST_CELL;
                     col_in   = COL_LAST;
                     row_in   = ROW_LAST;
                     state_in = ST_SCROLL;
                  end
                  FUNC_RENDER: begin
                     if (on_screen) begin
                        state_in = ST_RCELL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            // read issued now, write-back next cycle
            sc_wr_in    = 1'b1;
            sc_waddr_in = idx_ff;
            sc_space_in = vacated;
            if (inc) begin
               idx_in = idx_ff + CIDX_W'(1);
               if (col_ff == COL_LAST) begin
                  col_in = '0;
                  row_in = row_ff + RROW_W'(1);
               end else begin
                  col_in = col_ff + CCOL_W'(1);
               end
               if (idx_ff == LAST_CELL) begin
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff - CIDX_W'(1);
               if (col_ff == '0) begin
                  col_in = COL_LAST;
                  row_in = row_ff - RROW_W'(1);
               end else begin
                  col_in = col_ff - CCOL_W'(1);
               end
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RCELL: begin
            line_in  = '0;
            state_in = ST_RLINE;
         end
         ST_RLINE: begin
            if (line_issue) begin
               gl_pend_in = 1'b1;
               gl_line_in = line_ff;
               line_in    = line_ff + LINE_W'(1);
               if (line_ff == LAST_LINE) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         idx_ff     <= '0;
         sc_wr_ff   <= 1'b0;
         gl_pend_ff <= 1'b0;
         bg_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         sc_wr_ff   <= sc_wr_in;
         gl_pend_ff <= gl_pend_in;
         bg_ff      <= bg_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      op_ff       <= op_in;
      line_ff     <= line_in;
      sc_waddr_ff <= sc_waddr_in;
      sc_space_ff <= sc_space_in;
      gl_line_ff  <= gl_line_in;
   end

   // Pixel expansion and output beat
   assign job.glyph = gl_rd_ff;
   assign job.fore  = rd_cell_ff[COLOR_W-1:0];
   assign job.back  = bg_ff;
   assign job.line  = gl_line_ff;

   tsr_pixel_out u_pixel_out (
      .clock    (clock),
      .reset    (reset),
      .load     (gl_pend_ff),
      .job      (job),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== hdl/tsr_checker.sv =====
// Port-level checks for the text screen renderer, bound to the top level.
`timescale 1ns / 1ps

module tsr_checker import tsr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input func_type           req_func,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIX_W-1:0]   rsp_line_pixels,
   input logic [LINE_W-1:0]  rsp_line_number,
   input logic               rsp_last_line
);

   // Clearing pass holds off commands right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("command accepted during clearing pass");

   // A scroll keeps the block busy on the next cycle
   a_scroll_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_func == FUNC_SCROLL_UP || req_func == FUNC_SCROLL_LEFT ||
        req_func == FUNC_SCROLL_DOWN || req_func == FUNC_SCROLL_RIGHT))
      |=> !req_ready)
      else $error("ready right after a scroll beat");

   // Last-line flag matches the line number
   a_last_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_line == (rsp_line_number == LAST_LINE)))
      else $error("last_line does not match line_number");

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_line_pixels) && $stable(rsp_line_number)))
      else $error("stalled result beat changed");

endmodule

bind text_screen_scroll_and_glyph_render tsr_checker u_tsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_func        (req_chan.func),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_line_pixels (rsp_chan.line_pixels),
   .rsp_line_number (rsp_chan.line_number),
   .rsp_last_line   (rsp_chan.last_line)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the text screen renderer: directed table, then random commands.
`timescale 1ns / 1ps

module tb;
   import tsr_pkg::*;

   localparam int COLS           = SCREEN_COLUMNS_DEF;
   localparam int ROWS           = SCREEN_ROWS_DEF;
   localparam int CELLS          = COLS * ROWS;
   localparam int GBYTES         = GLYPH_BYTES_DEF;
   // a scroll keeps the block busy for about one cycle per cell
   localparam int SETTLE_CYCLES  = CELLS + 100;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 450;
   localparam int PHASES         = 5;
   localparam func_type FUNC_SPARE = 3'd7;

   typedef struct packed {
      func_type            func;
      logic [COL_W-1:0]    column;
      logic [ROW_W-1:0]    row_index;
      logic [CHAR_W-1:0]   char_code;
      logic [COLOR_W-1:0]  fore_color;
      logic [GADDR_W-1:0]  glyph_address;
      logic [GBYTE_W-1:0]  glyph_byte;
   } screen_cmd_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixels;
      logic [LINE_W-1:0]  number;
      logic               last;
   } line_beat_type;

   // how a directed row is checked
   typedef enum logic [1:0] {CHK_MODEL, CHK_BLANK, CHK_NONE} check_kind_type;

   typedef struct packed {
      screen_cmd_type      cmd;
      check_kind_type      kind;
      logic [PIX_W-1:0]    word;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en;
   logic [COLOR_W-1:0]  csr_wr_data;

   tsr_req_if req_if ();
   tsr_rsp_if rsp_if ();

   text_screen_scroll_and_glyph_render i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the screen, glyph store and background register
   logic [CHAR_W-1:0]   shadow_chars  [CELLS];
   logic [COLOR_W-1:0]  shadow_colors [CELLS];
   logic [GBYTE_W-1:0]  glyph_shadow  [GBYTES];
   bit                  glyph_valid   [GBYTES];
   logic [COLOR_W-1:0]  shadow_back;
   line_beat_type       pending_lines [$];

   int errors        = 0;
   int beats_checked = 0;
   int cmds_sent     = 0;
   int scrolls_sent  = 0;
   int renders_sent  = 0;
   int quiet_cycles  = 0;
   bit no_idle       = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void screen_reset();
      int i;
      for (i = 0; i < CELLS; i++) begin
         shadow_chars[i]  = SPACE_CODE;
         shadow_colors[i] = '0;
      end
      for (i = 0; i < GBYTES; i++) begin
         glyph_shadow[i] = '0;
         glyph_valid[i]  = 1'b0;
      end
      shadow_back = '0;
   endfunction

   function automatic void copy_cell(int dst, int src);
      shadow_chars[dst]  = shadow_chars[src];
      shadow_colors[dst] = shadow_colors[src];
   endfunction

   // Apply one command to the shadow state; a render queues its eight lines when emit is set
   function automatic void screen_apply(screen_cmd_type c, bit emit);
      int col, row, idx, gidx, r, cc, l, px;
      bit on_screen;
      logic [GBYTE_W-1:0] bits;
      logic [PIX_W-1:0]   word;
      line_beat_type      b;
      col       = int'(c.column);
      row       = int'(c.row_index);
      on_screen = (col < COLS) && (row < ROWS);
      idx       = row * COLS + col;
      case (c.func)
         FUNC_LOAD_GLYPH: begin
            gidx = int'(c.glyph_address) % GBYTES;
            glyph_shadow[gidx] = c.glyph_byte;
            glyph_valid[gidx]  = 1'b1;
         end
         FUNC_WRITE_CELL: begin
            if (on_screen) begin
               shadow_chars[idx]  = c.char_code;
               shadow_colors[idx] = c.fore_color;
            end
         end
         FUNC_SCROLL_UP: begin
            for (r = 0; r < ROWS - 1; r++)
               for (cc = 0; cc < COLS; cc++)
                  copy_cell(r * COLS + cc, (r + 1) * COLS + cc);
            for (cc = 0; cc < COLS; cc++)
               shadow_chars[(ROWS - 1) * COLS + cc] = SPACE_CODE;
         end
         FUNC_SCROLL_LEFT: begin
            for (cc = 0; cc < COLS - 1; cc++)
               for (r = 0; r < ROWS; r++)
                  copy_cell(r * COLS + cc, r * COLS + cc + 1);
            for (r = 0; r < ROWS; r++)
               shadow_chars[r * COLS + COLS - 1] = SPACE_CODE;
         end
         FUNC_SCROLL_DOWN: begin
            for (r = ROWS - 1; r > 0; r--)
               for (cc = 0; cc < COLS; cc++)
                  copy_cell(r * COLS + cc, (r - 1) * COLS + cc);
            for (cc = 0; cc < COLS; cc++)
               shadow_chars[cc] = SPACE_CODE;
         end
         FUNC_SCROLL_RIGHT: begin
            for (cc = COLS - 1; cc > 0; cc--)
               for (r = 0; r < ROWS; r++)
                  copy_cell(r * COLS + cc, r * COLS + cc - 1);
            for (r = 0; r < ROWS; r++)
               shadow_chars[r * COLS] = SPACE_CODE;
         end
         FUNC_RENDER: begin
            if (on_screen && emit) begin
               for (l = 0; l < GLYPH_LINES; l++) begin
                  gidx = (int'(shadow_chars[idx]) * GLYPH_LINES + l) % GBYTES;
                  bits = glyph_shadow[gidx];
                  word = '0;
                  // MSB of the glyph byte is the leftmost pixel
                  for (px = 0; px < 8; px++)
                     word = {word[PIX_W-5:0],
                             bits[7 - px] ? shadow_colors[idx] : shadow_back};
                  b.pixels = word;
                  b.number = LINE_W'(l);
                  b.last   = (l == GLYPH_LINES - 1);
                  pending_lines.push_back(b);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic screen_cmd_type random_cmd();
      screen_cmd_type c;
      c.func          = FUNC_SPARE;
      c.column        = COL_W'($urandom);
      c.row_index     = ROW_W'($urandom);
      c.char_code     = CHAR_W'($urandom);
      c.fore_color    = COLOR_W'($urandom);
      c.glyph_address = GADDR_W'($urandom);
      c.glyph_byte    = GBYTE_W'($urandom);
      return c;
   endfunction

   function automatic dir_row_type dir_row(func_type f, int col, int row, int chr, int fore,
                                           int gaddr, int gbyte, check_kind_type k,
                                           logic [PIX_W-1:0] w);
      dir_row_type d;
      d.cmd.func          = f;
      d.cmd.column        = COL_W'(col);
      d.cmd.row_index     = ROW_W'(row);
      d.cmd.char_code     = CHAR_W'(chr);
      d.cmd.fore_color    = COLOR_W'(fore);
      d.cmd.glyph_address = GADDR_W'(gaddr);
      d.cmd.glyph_byte    = GBYTE_W'(gbyte);
      d.kind              = k;
      d.word              = w;
      return d;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, want %h at %0t ns", field, got, want, $time);
      errors++;
   endtask

   // Drive one command beat, then update the shadow once it is accepted
   task automatic send_cmd(screen_cmd_type c, check_kind_type kind, logic [PIX_W-1:0] word);
      int gap, l;
      line_beat_type b;
      gap = no_idle ? 0 : int'($urandom_range(0, 9));
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.func          <= c.func;
      req_if.column        <= c.column;
      req_if.row_index     <= c.row_index;
      req_if.char_code     <= c.char_code;
      req_if.fore_color    <= c.fore_color;
      req_if.glyph_address <= c.glyph_address;
      req_if.glyph_byte    <= c.glyph_byte;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      screen_apply(c, kind == CHK_MODEL);
      if (kind == CHK_BLANK) begin
         for (l = 0; l < GLYPH_LINES; l++) begin
            b.pixels = word;
            b.number = LINE_W'(l);
            b.last   = (l == GLYPH_LINES - 1);
            pending_lines.push_back(b);
         end
      end
      cmds_sent++;
      if (c.func == FUNC_RENDER) renders_sent++;
      if (c.func >= FUNC_SCROLL_UP && c.func <= FUNC_SCROLL_RIGHT) scrolls_sent++;
   endtask

   // Load any glyph line of the cell's character that was never written
   task automatic prime_glyphs(int idx);
      screen_cmd_type c;
      int base, l;
      base = int'(shadow_chars[idx]) * GLYPH_LINES;
      for (l = 0; l < GLYPH_LINES; l++) begin
         if (!glyph_valid[base + l]) begin
            c = random_cmd();
            c.func = FUNC_LOAD_GLYPH;
            c.glyph_address = GADDR_W'(base + l);
            send_cmd(c, CHK_MODEL, '0);
         end
      end
   endtask

   // Hold off until every rendered line is back and any scroll has finished
   task automatic drain_and_settle();
      req_if.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_background(logic [COLOR_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_back = v;
   endtask

   // Result side: random stalls, compare each beat with the oldest expectation
   initial begin
      line_beat_type want;
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : int'($urandom_range(0, 9));
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         if (pending_lines.size() == 0) begin
            report("unexpected beat", rsp_if.line_pixels, '0);
         end else begin
            want = pending_lines.pop_front();
            if (rsp_if.line_pixels !== want.pixels)
               report("line_pixels", rsp_if.line_pixels, want.pixels);
            if (rsp_if.line_number !== want.number)
               report("line_number", 32'(rsp_if.line_number), 32'(want.number));
            if (rsp_if.last_line !== want.last)
               report("last_line", 32'(rsp_if.last_line), 32'(want.last));
            beats_checked++;
         end
      end
   end

   // Watchdog: cycles without any handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("[text_screen_scroll_and_glyph_render] ERROR");
         $finish;
      end
   end

   initial begin
      dir_row_type         table_rows [$];
      screen_cmd_type      c;
      logic [CHAR_W-1:0]   char_pool [8];
      logic [COLOR_W-1:0]  bg;
      int phase, start, pick, idx, i;

      req_if.valid         = 1'b0;
      req_if.func          = FUNC_LOAD_GLYPH;
      req_if.column        = '0;
      req_if.row_index     = '0;
      req_if.char_code     = '0;
      req_if.fore_color    = '0;
      req_if.glyph_address = '0;
      req_if.glyph_byte    = '0;
      rsp_if.ready         = 1'b0;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      screen_reset();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // space glyph, both ends of the glyph store
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 256, 8'hFF, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 257, 8'h00, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 258, 8'h80, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 259, 8'h01, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 260, 8'hAA, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 261, 8'h55, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 262, 8'hF0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 263, 8'h0F, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 2047, 8'hFF, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_LOAD_GLYPH, 0, 0, 0, 0, 0, 8'h00, CHK_MODEL, '0));
      // right after reset: space in color 0 on background 0 is all zero
      table_rows.push_back(dir_row(FUNC_RENDER, 0, 0, 0, 0, 0, 0, CHK_BLANK, 32'h0));
      table_rows.push_back(dir_row(FUNC_WRITE_CELL, 0, 0, 32, 15, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_WRITE_CELL, 39, 24, 32, 10, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_RENDER, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_RENDER, 39, 24, 0, 0, 0, 0, CHK_MODEL, '0));
      // cells off the screen: write ignored, render silent
      table_rows.push_back(dir_row(FUNC_WRITE_CELL, 63, 31, 255, 15, 0, 0, CHK_NONE, '0));
      table_rows.push_back(dir_row(FUNC_RENDER, 40, 0, 0, 0, 0, 0, CHK_NONE, '0));
      table_rows.push_back(dir_row(FUNC_RENDER, 0, 25, 0, 0, 0, 0, CHK_NONE, '0));
      table_rows.push_back(dir_row(FUNC_RENDER, 63, 31, 0, 0, 0, 0, CHK_NONE, '0));
      // unused code does nothing
      table_rows.push_back(dir_row(FUNC_SPARE, 63, 31, 255, 15, 2047, 255, CHK_NONE, '0));
      table_rows.push_back(dir_row(FUNC_WRITE_CELL, 20, 12, 255, 0, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_SCROLL_UP, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_SCROLL_LEFT, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_SCROLL_DOWN, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_SCROLL_RIGHT, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_RENDER, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
      table_rows.push_back(dir_row(FUNC_RENDER, 39, 24, 0, 0, 0, 0, CHK_MODEL, '0));

      foreach (table_rows[i])
         send_cmd(table_rows[i].cmd, table_rows[i].kind, table_rows[i].word);

      // a few codes that get reused so renders mostly hit loaded glyphs
      char_pool[0] = SPACE_CODE;
      for (i = 1; i < 8; i++) char_pool[i] = CHAR_W'($urandom);

      // Random phases, each with its own background and idling mode
      for (phase = 0; phase < PHASES; phase++) begin
         drain_and_settle();
         if (phase == 0)      bg = 4'd15;
         else if (phase == 2) bg = 4'd0;
         else                 bg = COLOR_W'($urandom);
         set_background(bg);
         no_idle = (phase == 3);
         start = cmds_sent;
         while (cmds_sent - start < RANDOM_ITEMS / PHASES) begin
            c = random_cmd();
            pick = int'($urandom_range(0, 99));
            if (pick < 20) begin
               c.func = FUNC_LOAD_GLYPH;
               send_cmd(c, CHK_MODEL, '0);
            end else if (pick < 45) begin
               // cell write, often followed by a render of the same cell
               c.func = FUNC_WRITE_CELL;
               if (pick < 43) begin
                  c.column    = COL_W'($urandom_range(0, COLS - 1));
                  c.row_index = ROW_W'($urandom_range(0, ROWS - 1));
               end
               if ($urandom_range(0, 9) < 7) c.char_code = char_pool[$urandom_range(0, 7)];
               send_cmd(c, CHK_MODEL, '0);
               if ($urandom_range(0, 1) == 1 && int'(c.column) < COLS &&
                   int'(c.row_index) < ROWS) begin
                  idx = int'(c.row_index) * COLS + int'(c.column);
                  prime_glyphs(idx);
                  c.func = FUNC_RENDER;
                  send_cmd(c, CHK_MODEL, '0);
               end
            end else if (pick < 50) begin
               c.func = func_type'($urandom_range(FUNC_SCROLL_UP, FUNC_SCROLL_RIGHT));
               send_cmd(c, CHK_MODEL, '0);
            end else if (pick < 52) begin
               c.func = FUNC_SPARE;
               send_cmd(c, CHK_MODEL, '0);
            end else if (pick < 56) begin
               // render off the screen
               c.func = FUNC_RENDER;
               if ($urandom_range(0, 1) == 1)
                  c.column = COL_W'($urandom_range(COLS, 63));
               else
                  c.row_index = ROW_W'($urandom_range(ROWS, 31));
               send_cmd(c, CHK_MODEL, '0);
            end else begin
               c.func      = FUNC_RENDER;
               c.column    = COL_W'($urandom_range(0, COLS - 1));
               c.row_index = ROW_W'($urandom_range(0, ROWS - 1));
               idx = int'(c.row_index) * COLS + int'(c.column);
               prime_glyphs(idx);
               send_cmd(c, CHK_MODEL, '0);
            end
            // now and then let everything drain before going on
            if ($urandom_range(0, 49) == 0) drain_and_settle();
         end
      end

      drain_and_settle();
      $display("Ran %0d commands: %0d renders, %0d scrolls, %0d rendered lines checked,",
               cmds_sent, renders_sent, scrolls_sent, beats_checked);
      $display("over %0d background settings, with and without idle cycles on both sides.",
               PHASES);
      if (errors == 0 && pending_lines.size() == 0) begin
         $display("[text_screen_scroll_and_glyph_render] OK");
      end else begin
         $display("[text_screen_scroll_and_glyph_render] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tsr_pkg.sv
hdl/tsr_channels.sv
hdl/tsr_pixel_out.sv
hdl/text_screen_scroll_and_glyph_render.sv
hdl/tsr_checker.sv
sim/tb.sv
